/* hdl/pfdc_pkg.sv */
// shared types and constants for the packet field distinct counter
package pfdc_pkg;

    // fixed widths of the ports and internal fields
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int OFFSET_W    = 16;
    localparam int LEN_W       = 4;
    localparam int POS_W       = 17;
    localparam int COUNT_OUT_W = 11;
    localparam int HASH_W      = 32;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // opcodes of an input item
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_OFFSET  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MOD,
        ST_MOD_SUB,
        ST_MOD_FIX,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic forward;
        logic new_value;
        logic too_short;
        logic table_overflow;
    } t_result;

endpackage

/* hdl/packet_field_distinct_counter.sv */
// top level of the packet field distinct counter: byte capture, hash set sequencer and memory
//
// Packets come in one byte per item (opcode byte); the bytes from field_offset on,
// field_length of them, are packed little-endian into a key. Bytes that are not the
// last of their packet give no result and leave the block ready for the next byte.
// On the last byte one result item comes out; unless the packet is too short for
// the field, the key is first looked up in a hash set of TABLE_ENTRIES keys held in
// a single-port-write, registered-read memory. The lookup runs on one shared compare
// unit under a small sequencer: the byte is taken, then, when TABLE_ENTRIES is not a
// power of two, one shared multiplier forms the bucket index (reciprocal quotient,
// subtract, final correction), then each probe is a memory read and a compare, with
// linear probing, and then the result is loaded into the output register once free.
// A lookup makes up to TABLE_ENTRIES probes when the set is full. A packet too
// short for the field skips the lookup and goes straight to the result. A clear
// item, and reset, start a sweep that writes every entry invalid, during which no
// item is taken; configuration writes are taken at all times but are only meant
// while the block is idle. The output register lets the next packet's bytes flow in
// while a result waits.
module packet_field_distinct_counter
    import pfdc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wr_data,
    // input items
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    // result items
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_forward,
    output logic                   o_new_value,
    output logic                   o_too_short,
    output logic                   o_table_overflow,
    output logic [COUNT_OUT_W-1:0] o_unique_count
);

    localparam int  KEY_W    = 8 * MAX_KEY_BYTES;
    localparam int  IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int  CNT_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int  MEM_W    = KEY_W + 1;
    localparam int  SHIFT_W  = HASH_W + IDX_W;
    localparam bit  IS_POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  PROBE_LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [HASH_W-1:0] MOD_N      = HASH_W'(TABLE_ENTRIES);
    // reciprocal of the table size, scaled so the quotient is at most one low
    localparam logic [HASH_W:0]   MOD_REC    =
        (HASH_W + 1)'((64'd1 << SHIFT_W) / 64'(TABLE_ENTRIES));

    // control state
    t_state                 r_state, n_state;
    logic [OFFSET_W-1:0]    r_offset, n_offset;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_filter, n_filter;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_probes, n_probes;
    logic                   r_out_valid, n_out_valid;

    // payload state
    logic [KEY_W-1:0]       r_lookup_key, n_lookup_key;
    logic [HASH_W-1:0]      r_hash, n_hash;
    logic [HASH_W-1:0]      r_quot, n_quot;
    t_result                r_res, n_res;
    t_result                r_out, n_out;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;

    // key memory: valid bit on top of the stored key
    logic [MEM_W-1:0]       r_mem [TABLE_ENTRIES];
    logic [MEM_W-1:0]       r_rd_data;
    logic                   mem_we;
    logic                   mem_re;
    logic [MEM_W-1:0]       mem_wdata;

    // byte capture
    logic [LEN_W-1:0]       eff_len;
    logic [POS_W-1:0]       lane_off;
    logic                   in_field;
    logic [KEY_W-1:0]       key_merged;
    logic [POS_W-1:0]       pos_inc;
    logic                   is_short;
    logic [63:0]            key_ext;
    logic [HASH_W-1:0]      fold;

    // probe compare and shared remainder multiplier
    logic                   hit;
    logic [HASH_W:0]        mul_a;
    logic [HASH_W:0]        mul_b;
    logic [2*HASH_W+1:0]    mul_p;

    // field length 0 acts as 1, above the key size acts as the key size
    always_comb begin
        priority if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_KEY_BYTES)) begin
            eff_len = LEN_W'(MAX_KEY_BYTES);
        end else begin
            eff_len = r_len;
        end
    end

    // merge the incoming byte into its key lane
    always_comb begin
        key_merged = r_key;
        lane_off   = r_pos - POS_W'(r_offset);
        in_field   = (r_pos >= POS_W'(r_offset)) && (lane_off < POS_W'(eff_len));
        for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            if (in_field && (lane_off == POS_W'(b))) begin
                key_merged[8*b +: 8] = i_data_byte;
            end
        end
    end

    assign pos_inc  = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    assign is_short = pos_inc < (POS_W'(r_offset) + POS_W'(eff_len));
    assign key_ext  = 64'(key_merged);
    assign fold     = key_ext[31:0] ^ key_ext[63:32];

    assign hit   = r_rd_data[KEY_W-1:0] == r_lookup_key;

    // one multiplier: fold times reciprocal, then quotient times table size
    assign mul_a = (r_state == ST_MOD) ? {1'b0, r_hash} : {1'b0, r_quot};
    assign mul_b = (r_state == ST_MOD) ? MOD_REC : {1'b0, MOD_N};
    assign mul_p = {{(HASH_W + 1){1'b0}}, mul_a} * {{(HASH_W + 1){1'b0}}, mul_b};

    always_comb begin
        n_state      = r_state;
        n_offset     = r_offset;
        n_len        = r_len;
        n_filter     = r_filter;
        n_pos        = r_pos;
        n_key        = r_key;
        n_idx        = r_idx;
        n_count      = r_count;
        n_probes     = r_probes;
        n_out_valid  = r_out_valid;
        n_lookup_key = r_lookup_key;
        n_hash       = r_hash;
        n_quot       = r_quot;
        n_res        = r_res;
        n_out        = r_out;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = '0;

        // configuration
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FIELD_OFFSET:  n_offset = i_cfg_wr_data[OFFSET_W-1:0];
                REG_FIELD_LENGTH:  n_len    = i_cfg_wr_data[LEN_W-1:0];
                REG_FILTER_ENABLE: n_filter = i_cfg_wr_data[0];
                default: ;
            endcase
        end

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_CLEAR) begin
                        n_pos   = '0;
                        n_key   = '0;
                        n_count = '0;
                        n_idx   = '0;
                        n_state = ST_CLEAR;
                    end else begin
                        n_pos = pos_inc;
                        n_key = key_merged;
                        if (i_last_byte) begin
                            n_pos        = '0;
                            n_key        = '0;
                            n_lookup_key = key_merged;
                            n_probes     = '0;
                            if (is_short) begin
                                n_res   = '{forward: 1'b1, new_value: 1'b0,
                                            too_short: 1'b1, table_overflow: 1'b0};
                                n_state = ST_RESULT;
                            end else if (IS_POW2) begin
                                n_idx   = fold[IDX_W-1:0];
                                n_state = ST_PROBE_RD;
                            end else begin
                                n_hash  = fold;
                                n_state = ST_MOD;
                            end
                        end
                    end
                end
            end

            // invalidate one entry per cycle
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // quotient estimate, equal to the true one or one below
            ST_MOD: begin
                n_quot  = HASH_W'(mul_p >> SHIFT_W);
                n_state = ST_MOD_SUB;
            end

            // partial remainder, below twice the table size
            ST_MOD_SUB: begin
                n_hash  = r_hash - mul_p[HASH_W-1:0];
                n_state = ST_MOD_FIX;
            end

            ST_MOD_FIX: begin
                n_idx   = (r_hash >= MOD_N) ? IDX_W'(r_hash - MOD_N) : IDX_W'(r_hash);
                n_state = ST_PROBE_RD;
            end

            ST_PROBE_RD: begin
                mem_re  = 1'b1;
                n_state = ST_PROBE_CMP;
            end

            ST_PROBE_CMP: begin
                priority if (!r_rd_data[MEM_W-1]) begin
                    // empty slot: store and count
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, r_lookup_key};
                    n_count   = r_count + CNT_W'(1);
                    n_res     = '{forward: 1'b1, new_value: 1'b1,
                                  too_short: 1'b0, table_overflow: 1'b0};
                    n_state   = ST_RESULT;
                end else if (hit) begin
                    n_res   = '{forward: !r_filter, new_value: 1'b0,
                                too_short: 1'b0, table_overflow: 1'b0};
                    n_state = ST_RESULT;
                end else if (r_probes == PROBE_LAST) begin
                    // every slot taken by some other key
                    n_res   = '{forward: 1'b1, new_value: 1'b1,
                                too_short: 1'b0, table_overflow: 1'b1};
                    n_state = ST_RESULT;
                end else begin
                    n_idx    = (r_idx == IDX_LAST) ? '0 : r_idx + IDX_W'(1);
                    n_probes = r_probes + CNT_W'(1);
                    n_state  = ST_PROBE_RD;
                end
            end

            // wait for the output register to free up
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_count = COUNT_OUT_W'(r_count);
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_offset    <= '0;
            r_len       <= LEN_W'(1);
            r_filter    <= 1'b0;
            r_pos       <= '0;
            r_key       <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_probes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_offset    <= n_offset;
            r_len       <= n_len;
            r_filter    <= n_filter;
            r_pos       <= n_pos;
            r_key       <= n_key;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_probes    <= n_probes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lookup_key <= n_lookup_key;
        r_hash       <= n_hash;
        r_quot       <= n_quot;
        r_res        <= n_res;
        r_out        <= n_out;
        r_out_count  <= n_out_count;
    end

    // key memory, one write and one registered read at the current index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign o_in_ready       = r_state == ST_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_forward        = r_out.forward;
    assign o_new_value      = r_out.new_value;
    assign o_too_short      = r_out.too_short;
    assign o_table_overflow = r_out.table_overflow;
    assign o_unique_count   = r_out_count;

endmodule

/* hdl/pfdc_checker.sv */
// port-level assertions for the packet field distinct counter and their bind
module pfdc_checker
    import pfdc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   i_opcode,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic                   o_forward,
    input logic                   o_new_value,
    input logic                   o_too_short,
    input logic                   o_table_overflow,
    input logic [COUNT_OUT_W-1:0] o_unique_count
);

    // short packet passes uncounted
    a_short_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_too_short |-> o_forward && !o_new_value && !o_table_overflow)
        else $error("short packet result flags inconsistent");

    // overflow only on a new key, which always passes
    a_overflow_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_overflow |-> o_new_value && o_forward && !o_too_short)
        else $error("overflow result flags inconsistent");

    // only a seen key is dropped
    a_drop_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_forward |-> !o_new_value && !o_too_short)
        else $error("dropped packet reported as new or short");

    // a clear item starts the invalidation sweep
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_CLEAR) |=> !o_in_ready)
        else $error("input taken right after a clear item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_unique_count))
        else $error("stalled result item changed");

endmodule

bind packet_field_distinct_counter pfdc_checker u_pfdc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_opcode         (i_opcode),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_forward        (o_forward),
    .o_new_value      (o_new_value),
    .o_too_short      (o_too_short),
    .o_table_overflow (o_table_overflow),
    .o_unique_count   (o_unique_count)
);
